@@ rtl/core/ncd_pkg.sv @@
package ncd_pkg;

	// Field widths of the request and result items, and the number of reported cars
	localparam int FLOOR_W       = 6;
	localparam int CAR_FIELD_W   = 2;
	localparam int MASK_W        = 3;
	localparam int REPORTED_CARS = 3;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_TICK    = 1'b1
	} ncd_op_t;

	typedef struct packed {
		ncd_op_t              opcode;
		logic [FLOOR_W-1:0]   floor;
	} ncd_req_t;

	typedef struct packed {
		logic [CAR_FIELD_W-1:0] assigned_car;
		logic                   accepted;
		logic [MASK_W-1:0]      moved_mask;
		logic [FLOOR_W-1:0]     car0_floor;
		logic [FLOOR_W-1:0]     car1_floor;
		logic [FLOOR_W-1:0]     car2_floor;
	} ncd_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DRAIN,
		ST_REPORT
	} ncd_state_t;

endpackage

@@ rtl/core/ncd_ram.sv @@
module ncd_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 24
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/ncd_nearest.sv @@
module ncd_nearest #(
	parameter int NUM_CARS   = 3,
	parameter int FLOOR_BITS = 6
) (
	input  logic [NUM_CARS-1:0][FLOOR_BITS-1:0]                car_floor,
	input  logic [FLOOR_BITS-1:0]                              target,
	output logic [((NUM_CARS > 1) ? $clog2(NUM_CARS) : 1)-1:0] car
);

	localparam int CAR_W = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;

	logic [NUM_CARS-1:0][FLOOR_BITS-1:0] car_dist;
	logic [FLOOR_BITS-1:0]               best_dist;
	logic [CAR_W-1:0]                    best;

	for (genvar k = 0; k < NUM_CARS; k++) begin : g_dist
		assign car_dist[k] = (car_floor[k] > target) ? (car_floor[k] - target)
		                                             : (target - car_floor[k]);
	end

	// Strict compare keeps the lowest-numbered car on a tie.
	always_comb begin
		best      = '0;
		best_dist = car_dist[0];
		for (int k = 1; k < NUM_CARS; k++) begin
			if (car_dist[k] < best_dist) begin
				best_dist = car_dist[k];
				best      = CAR_W'(k);
			end
		end
		car = best;
	end

endmodule

@@ rtl/core/nearest_car_dispatch_queues_core.sv @@
// Request: done strobes in the next cycle; a new request can follow every cycle unless busy.
// Tick: the shared destination RAM is read once per non-empty queue, so busy stays high
// through TICK, DRAIN and REPORT until the result strobes (one read port sets this).
// Results cannot be stalled by the receiver; done is high for exactly one cycle per item.
// Reset (arst_n low, asynchronous) empties all queues and puts every car at floor 0;
// the destination RAM itself is not cleared, since an entry is read only after it was written.
module nearest_car_dispatch_queues_core #(
	parameter int NUM_CARS    = 3,
	parameter int QUEUE_DEPTH = 8,
	parameter int FLOOR_BITS  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ncd_pkg::ncd_req_t request,
	output logic              busy,
	output logic              done,
	output ncd_pkg::ncd_rsp_t result
);

	import ncd_pkg::*;

	localparam int CAR_W     = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_CARS * QUEUE_DEPTH;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int FLOOR_XW  = (FLOOR_BITS > FLOOR_W) ? FLOOR_BITS : FLOOR_W;
	localparam int CAR_XW    = (CAR_W > CAR_FIELD_W) ? CAR_W : CAR_FIELD_W;
	localparam int MASK_XW   = (NUM_CARS > MASK_W) ? NUM_CARS : MASK_W;

	// Sequencer state and the car being visited during a tick.
	ncd_state_t       state_q;
	ncd_state_t       state_d;
	logic [CAR_W-1:0] tick_car_q;

	// Per-car queue bookkeeping. These are small and each entry is used at its own
	// place, so they live in flops; only the destination floors sit in the RAM.
	logic [NUM_CARS-1:0][PTR_W-1:0]      head_q;
	logic [NUM_CARS-1:0][PTR_W-1:0]      tail_q;
	logic [NUM_CARS-1:0][CNT_W-1:0]      count_q;
	logic [NUM_CARS-1:0][FLOOR_BITS-1:0] floor_q;
	logic [NUM_CARS-1:0]                 moved_q;

	// Read pipeline: a pop issued in one cycle returns its floor in the next.
	logic             pop_s1;
	logic [CAR_W-1:0] car_s1;

	ncd_rsp_t result_q;
	ncd_rsp_t result_d;
	logic     done_q;
	logic     load_result;

	logic                    accept_req;
	logic                    accept_tick;
	logic [FLOOR_XW-1:0]     req_floor_x;
	logic [FLOOR_BITS-1:0]   req_floor;
	logic [CAR_W-1:0]        chosen_car;
	logic [CAR_XW-1:0]       chosen_car_x;
	logic                    chosen_full;
	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic                    pop_now;
	logic                    tick_last;
	logic [ADDR_W-1:0]       rd_addr;
	logic [FLOOR_BITS-1:0]   rd_data;
	logic [MASK_XW-1:0]      moved_x;
	logic [REPORTED_CARS-1:0][FLOOR_W-1:0] rep_floor;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// The request floor is resized to the stored floor width.
	assign req_floor_x = FLOOR_XW'(request.floor);
	assign req_floor   = req_floor_x[FLOOR_BITS-1:0];

	assign accept_req  = start && !busy && (request.opcode == OP_REQUEST);
	assign accept_tick = start && !busy && (request.opcode == OP_TICK);

	ncd_nearest #(
		.NUM_CARS   (NUM_CARS),
		.FLOOR_BITS (FLOOR_BITS)
	) u_nearest (
		.car_floor (floor_q),
		.target    (req_floor),
		.car       (chosen_car)
	);

	// A request writes its floor straight into the tail slot of the chosen car.
	// A full queue drops the request but still reports the chosen car.
	assign chosen_full = (count_q[chosen_car] == CNT_W'(QUEUE_DEPTH));
	assign wr_en       = accept_req && !chosen_full;
	assign wr_addr     = ADDR_W'(chosen_car) * ADDR_W'(QUEUE_DEPTH)
	                   + ADDR_W'(tail_q[chosen_car]);

	// A tick walks the cars in order, one RAM read per non-empty queue. Head and
	// count move when the read is issued; the floor lands in the cycle after. Writes
	// only happen while idle, so a read never races a write to the same slot.
	assign pop_now   = (state_q == ST_TICK) && (count_q[tick_car_q] != '0);
	assign tick_last = (tick_car_q == CAR_W'(NUM_CARS - 1));
	assign rd_addr   = ADDR_W'(tick_car_q) * ADDR_W'(QUEUE_DEPTH)
	                 + ADDR_W'(head_q[tick_car_q]);

	ncd_ram #(
		.WIDTH (FLOOR_BITS),
		.DEPTH (MEM_DEPTH)
	) u_dest_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req_floor),
		.rd_en   (pop_now),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The tick runs TICK for every car, DRAIN for the last read to land, and
	// REPORT once all floors are settled.
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept_tick) begin
					state_d = ST_TICK;
				end
			end
			ST_TICK: begin
				if (tick_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_car_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			floor_q    <= '0;
			moved_q    <= '0;
			pop_s1     <= 1'b0;
			car_s1     <= '0;
			done_q     <= 1'b0;
		end else begin
			pop_s1 <= pop_now;
			car_s1 <= tick_car_q;
			done_q <= load_result;

			if (accept_tick) begin
				tick_car_q <= '0;
				moved_q    <= '0;
			end else if ((state_q == ST_TICK) && !tick_last) begin
				tick_car_q <= tick_car_q + 1'b1;
			end

			for (int c = 0; c < NUM_CARS; c++) begin
				if (wr_en && (chosen_car == CAR_W'(c))) begin
					tail_q[c]  <= next_slot(tail_q[c]);
					count_q[c] <= count_q[c] + 1'b1;
				end
				if (pop_now && (tick_car_q == CAR_W'(c))) begin
					head_q[c]  <= next_slot(head_q[c]);
					count_q[c] <= count_q[c] - 1'b1;
					moved_q[c] <= 1'b1;
				end
				if (pop_s1 && (car_s1 == CAR_W'(c))) begin
					floor_q[c] <= rd_data;
				end
			end
		end
	end

	// Floors reported on the three result fields; absent cars read as ground floor.
	for (genvar k = 0; k < REPORTED_CARS; k++) begin : g_rep
		if (k < NUM_CARS) begin : g_car
			logic [FLOOR_XW-1:0] floor_x;
			assign floor_x      = FLOOR_XW'(floor_q[k]);
			assign rep_floor[k] = floor_x[FLOOR_W-1:0];
		end else begin : g_none
			assign rep_floor[k] = '0;
		end
	end

	assign chosen_car_x = CAR_XW'(chosen_car);
	assign moved_x      = MASK_XW'(moved_q);
	assign load_result  = accept_req || (state_q == ST_REPORT);

	// A request result carries the unchanged floors; a tick result is built in
	// REPORT, after the last popped floor was written back.
	always_comb begin
		result_d            = '0;
		result_d.car0_floor = rep_floor[0];
		result_d.car1_floor = rep_floor[1];
		result_d.car2_floor = rep_floor[2];
		if (state_q == ST_REPORT) begin
			result_d.moved_mask = moved_x[MASK_W-1:0];
		end else begin
			result_d.assigned_car = chosen_car_x[CAR_FIELD_W-1:0];
			result_d.accepted     = !chosen_full;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	// A request strobes done in the next cycle and leaves the block free.
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept_req |=> done && !busy)
		else $error("request result did not strobe on the next cycle");

	// A tick keeps the block busy and shows no result right away.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept_tick |=> busy && !done)
		else $error("tick did not hold the block busy");

	// Read data is only written back for pops issued while walking the cars.
	a_pop_origin: assert property (@(posedge clk) disable iff (!arst_n)
		pop_s1 |-> $past(state_q) == ST_TICK)
		else $error("read data returned without a pop in the tick walk");

	// A result never claims both a queued request and moved cars.
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.accepted && (result.moved_mask != '0)))
		else $error("result marks a request and a move at once");

	for (genvar c = 0; c < NUM_CARS; c++) begin : g_chk
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[c] <= CNT_W'(QUEUE_DEPTH))
			else $error("queue count exceeds queue depth");
	end

endmodule
